### rtl/mbrm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbrm_pkg
// Shared sizes, codes and reset contents of the Modbus slave register map.
// ----------------------------------------------------------------------------
package mbrm_pkg;

    // Bank sizes
    localparam int HOLDING_COUNT  = 256;
    localparam int INPUT_COUNT    = 8;
    localparam int COIL_COUNT     = 16;
    localparam int DISCRETE_COUNT = 16;

    localparam int HOLDING_AW = (HOLDING_COUNT > 1) ? $clog2(HOLDING_COUNT) : 1;
    localparam int BIT_MAX    = (COIL_COUNT > DISCRETE_COUNT) ? COIL_COUNT : DISCRETE_COUNT;
    localparam int BPOS_W     = $clog2(BIT_MAX);

    localparam int WORD_W = 16;

    // Reset contents
    localparam logic [WORD_W-1:0] INPUT_BASE     = 16'h1000;
    localparam logic [WORD_W-1:0] BIT_RESET_WORD = 16'h0201;
    localparam logic [7:0]        BYTE_ALL_ONES  = 8'hFF;

    localparam logic [COIL_COUNT-1:0]     COIL_RESET = COIL_COUNT'(BIT_RESET_WORD);
    localparam logic [DISCRETE_COUNT-1:0] DISC_RESET = DISCRETE_COUNT'(BIT_RESET_WORD);

    // Stream packing
    localparam int S_TDATA_W = 56;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 16;
    localparam int M_TUSER_W = 2;

    typedef enum logic [2:0] {
        OP_RD_INPUT    = 3'd0,
        OP_RD_HOLDING  = 3'd1,
        OP_WR_HOLDING  = 3'd2,
        OP_RD_COILS    = 3'd3,
        OP_WR_COILS    = 3'd4,
        OP_RD_DISCRETE = 3'd5
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_NOREG  = 2'd1,
        ST_BEYOND = 2'd2
    } status_t;

    // Input register bank contents (read only)
    function automatic logic [WORD_W-1:0] input_reg_word(input logic [16:0] addr);
        return INPUT_BASE + WORD_W'(addr);
    endfunction

endpackage

### rtl/mbrm_hold_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbrm_hold_ram
// Holding register store: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module mbrm_hold_ram (
    input  logic                                aclk,
    input  logic                                we,
    input  logic [mbrm_pkg::HOLDING_AW-1:0]     waddr,
    input  logic [mbrm_pkg::WORD_W-1:0]         wdata,
    input  logic                                re,
    input  logic [mbrm_pkg::HOLDING_AW-1:0]     raddr,
    output logic [mbrm_pkg::WORD_W-1:0]         rdata
);
    import mbrm_pkg::*;

    logic [WORD_W-1:0] mem [HOLDING_COUNT];
    logic [WORD_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Hold the last read word until the next read
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/modbus_register_map.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modbus_register_map
// Modbus slave register map, one request element per beat.
// ----------------------------------------------------------------------------
// Pipeline: two register stages from input beat to result beat (decode/RAM
//   read, output). Throughput: 1 beat per cycle while m_tready is high; the
//   holding RAM's single registered read port sets the two-stage depth.
// Reset: synchronous, active low. After reset the holding bank is swept to
//   zero, one entry per cycle (HOLDING_COUNT = 256 entries), with s_tready low.
// ----------------------------------------------------------------------------
module modbus_register_map (
    input  logic                               aclk,
    input  logic                               aresetn,
    // Request element
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // start_address[15:0], quantity[31:16], element_index[39:32],
    // write_data[55:40]
    input  logic [mbrm_pkg::S_TDATA_W-1:0]     s_tdata,
    // opcode[2:0]
    input  logic [mbrm_pkg::S_TUSER_W-1:0]     s_tuser,
    // Result
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // read_data[15:0]
    output logic [mbrm_pkg::M_TDATA_W-1:0]     m_tdata,
    // status[1:0]
    output logic [mbrm_pkg::M_TUSER_W-1:0]     m_tuser
);
    import mbrm_pkg::*;

    // ------------------------------------------------------------------
    // Unpack the request beat
    // ------------------------------------------------------------------
    opcode_t      opcode;
    logic [15:0]  start_address;
    logic [15:0]  quantity;
    logic [7:0]   element_index;
    logic [15:0]  write_data;

    assign opcode        = opcode_t'(s_tuser);
    assign start_address = s_tdata[15:0];
    assign quantity      = s_tdata[31:16];
    assign element_index = s_tdata[39:32];
    assign write_data    = s_tdata[55:40];

    // ------------------------------------------------------------------
    // Control and state registers
    // ------------------------------------------------------------------
    logic                    clearing_reg;
    logic [HOLDING_AW-1:0]   clr_cnt_reg;
    logic                    s1_valid_reg;
    status_t                 s1_status_reg;
    logic [WORD_W-1:0]       s1_rdata_reg;
    logic                    s1_use_ram_reg;
    logic                    m_tvalid_reg;
    logic [M_TDATA_W-1:0]    m_tdata_reg;
    status_t                 m_tuser_reg;
    logic [COIL_COUNT-1:0]   coil_reg;

    logic s_accept;
    logic s1_advance;

    // Advance the decode stage when the output register is free or drains
    assign s1_advance = s1_valid_reg && (!m_tvalid_reg || m_tready);
    assign s_tready   = !clearing_reg && (!s1_valid_reg || s1_advance);
    assign s_accept   = s_tvalid && s_tready;

    // ------------------------------------------------------------------
    // Range checks
    // ------------------------------------------------------------------
    logic [16:0] reg_end;        // start + quantity for the input bank
    logic [15:0] hold_base;      // one-based start made zero-based
    logic [16:0] hold_end;
    logic        hold_start_ok;
    logic [16:0] bit_end;
    logic [16:0] byte_count;     // ceil(quantity / 8)
    logic [16:0] bits_left;
    logic [3:0]  bits_n;
    logic [7:0]  bits_mask;
    logic [16:0] bit_pos_full;
    logic [BPOS_W-1:0] bit_pos;
    logic [16:0] input_addr;
    logic [HOLDING_AW-1:0] hold_addr;

    assign reg_end       = {1'b0, start_address} + {1'b0, quantity};
    assign hold_base     = start_address - 16'd1;
    assign hold_end      = {1'b0, hold_base} + {1'b0, quantity};
    assign hold_start_ok = (start_address != 16'd0);
    assign bit_end       = reg_end;
    assign byte_count    = ({1'b0, quantity} + 17'd7) >> 3;
    assign bits_left     = {1'b0, quantity} - {6'd0, element_index, 3'b000};
    assign bits_n        = (bits_left > 17'd8) ? 4'd8 : bits_left[3:0];
    assign bits_mask     = (bits_n >= 4'd8) ? BYTE_ALL_ONES : ((8'd1 << bits_n) - 8'd1);
    // Element k of a bit request starts at bit start + 8 * k
    assign bit_pos_full  = {1'b0, start_address} + {6'd0, element_index, 3'b000};
    assign bit_pos       = bit_pos_full[BPOS_W-1:0];
    assign input_addr    = {1'b0, start_address} + {9'd0, element_index};
    assign hold_addr     = HOLDING_AW'(hold_base + {8'd0, element_index});

    // ------------------------------------------------------------------
    // Bit banks: extract or merge one byte at bit_pos
    // ------------------------------------------------------------------
    logic [COIL_COUNT+7:0]     coil_shifted;
    logic [DISCRETE_COUNT+7:0] disc_shifted;
    logic [COIL_COUNT+7:0]     coil_mask_ext;
    logic [COIL_COUNT+7:0]     coil_data_ext;
    logic [COIL_COUNT-1:0]     coil_mask;
    logic [COIL_COUNT-1:0]     coil_next;

    assign coil_shifted  = {8'd0, coil_reg} >> bit_pos;
    assign disc_shifted  = {8'd0, DISC_RESET} >> bit_pos;
    assign coil_mask_ext = {{COIL_COUNT{1'b0}}, bits_mask} << bit_pos;
    assign coil_data_ext = {{COIL_COUNT{1'b0}}, write_data[7:0] & bits_mask} << bit_pos;
    assign coil_mask     = coil_mask_ext[COIL_COUNT-1:0];
    assign coil_next     = (coil_reg & ~coil_mask) | (coil_data_ext[COIL_COUNT-1:0] & coil_mask);

    // ------------------------------------------------------------------
    // Decode one request element
    // ------------------------------------------------------------------
    status_t           status_next;
    logic [WORD_W-1:0] rdata_next;
    logic              use_ram_next;
    logic              hold_rd_en;
    logic              hold_wr_en;
    logic              coil_wr_en;

    always_comb begin
        status_next  = ST_OK;
        rdata_next   = '0;
        use_ram_next = 1'b0;
        hold_rd_en   = 1'b0;
        hold_wr_en   = 1'b0;
        coil_wr_en   = 1'b0;
        unique case (opcode)
            OP_RD_INPUT: begin
                if (reg_end > 17'(INPUT_COUNT)) begin
                    status_next = ST_NOREG;
                end else if ({8'd0, element_index} >= quantity) begin
                    status_next = ST_BEYOND;
                end else begin
                    rdata_next = input_reg_word(input_addr);
                end
            end
            OP_RD_HOLDING, OP_WR_HOLDING: begin
                if (!hold_start_ok || hold_end > 17'(HOLDING_COUNT)) begin
                    status_next = ST_NOREG;
                end else if ({8'd0, element_index} >= quantity) begin
                    status_next = ST_BEYOND;
                end else if (opcode == OP_RD_HOLDING) begin
                    use_ram_next = 1'b1;
                    hold_rd_en   = 1'b1;
                end else begin
                    hold_wr_en = 1'b1;
                end
            end
            OP_RD_COILS, OP_WR_COILS: begin
                if (bit_end > 17'(COIL_COUNT)) begin
                    status_next = ST_NOREG;
                end else if ({9'd0, element_index} >= byte_count) begin
                    status_next = ST_BEYOND;
                end else if (opcode == OP_RD_COILS) begin
                    rdata_next = {8'd0, coil_shifted[7:0] & bits_mask};
                end else begin
                    coil_wr_en = 1'b1;
                end
            end
            OP_RD_DISCRETE: begin
                if (bit_end > 17'(DISCRETE_COUNT)) begin
                    status_next = ST_NOREG;
                end else if ({9'd0, element_index} >= byte_count) begin
                    status_next = ST_BEYOND;
                end else begin
                    rdata_next = {8'd0, disc_shifted[7:0] & bits_mask};
                end
            end
            default: begin
                status_next = ST_NOREG;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Holding RAM: sweep to zero after reset, then serve requests.
    // A write lands at its accept edge, so any later read sees it.
    // ------------------------------------------------------------------
    logic                  ram_we;
    logic [HOLDING_AW-1:0] ram_waddr;
    logic [WORD_W-1:0]     ram_wdata;
    logic                  ram_re;
    logic [WORD_W-1:0]     ram_rdata;

    assign ram_we    = clearing_reg || (s_accept && hold_wr_en);
    assign ram_waddr = clearing_reg ? clr_cnt_reg : hold_addr;
    assign ram_wdata = clearing_reg ? '0 : write_data;
    assign ram_re    = s_accept && hold_rd_en;

    mbrm_hold_ram u_hold_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (hold_addr),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Clocked state
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clearing_reg <= 1'b1;
            clr_cnt_reg  <= '0;
            s1_valid_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
            coil_reg     <= COIL_RESET;
        end else begin
            // Sweep the holding bank one entry per cycle
            if (clearing_reg) begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == HOLDING_AW'(HOLDING_COUNT - 1)) begin
                    clearing_reg <= 1'b0;
                end
            end
            if (s_accept && coil_wr_en) begin
                coil_reg <= coil_next;
            end
            if (s_accept) begin
                s1_valid_reg <= 1'b1;
            end else if (s1_advance) begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_advance) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Payload: no reset needed
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_status_reg  <= status_next;
            s1_rdata_reg   <= rdata_next;
            s1_use_ram_reg <= use_ram_next;
        end
        if (s1_advance) begin
            m_tdata_reg <= s1_use_ram_reg ? ram_rdata : s1_rdata_reg;
            m_tuser_reg <= s1_status_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_no_accept_while_clearing: assert property (
        @(posedge aclk) disable iff (!aresetn)
        clearing_reg |-> !s_tready
    ) else $error("request accepted during holding bank sweep");

    a_error_reads_zero: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser != ST_OK) |-> (m_tdata == '0)
    ) else $error("error result carries nonzero read data");

    a_stage_holds_on_stall: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && m_tvalid && !m_tready) |=> s1_valid_reg
    ) else $error("decode stage lost an element under output stall");

    a_ram_write_source: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (ram_we && !clearing_reg) |-> (s_accept && opcode == OP_WR_HOLDING)
    ) else $error("holding RAM written without a holding write beat");

    a_single_ram_access: assert property (
        @(posedge aclk) disable iff (!aresetn)
        ram_re |-> !ram_we
    ) else $error("holding RAM read and written in one cycle");

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the Modbus slave register map.
// Request elements go in on the s_ stream and answers come back on the m_
// stream. A model of the holding, input, coil and discrete banks inside the
// bench predicts each answer and queues it. Each answer beat is compared
// with the oldest queued prediction. A short table of directed elements
// comes first. Random requests follow, mostly well-formed with some noise,
// with bursts of stalls on both streams.
// ----------------------------------------------------------------------------
module testbench;
    import mbrm_pkg::*;

    // Opcodes the block does not implement; both must answer "no register"
    localparam logic [2:0] OP_SPARE_6 = 3'd6;
    localparam logic [2:0] OP_SPARE_7 = 3'd7;

    localparam int RANDOM_ELEMENTS = 800;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int MAX_REPORTS     = 10;
    localparam int TAIL_CYCLES     = 8;

    typedef struct packed {
        logic [2:0]  op;
        logic [15:0] start_addr;
        logic [15:0] qty;
        logic [7:0]  idx;
        logic [15:0] wdata;
    } request_t;

    typedef struct packed {
        status_t     st;
        logic [15:0] rdata;
    } answer_t;

    // Directed row: request, plus an answer typed in where it is obvious
    typedef struct packed {
        logic [2:0]  op;
        logic [15:0] start_addr;
        logic [15:0] qty;
        logic [7:0]  idx;
        logic [15:0] wdata;
        bit          typed;
        status_t     st;
        logic [15:0] rdata;
    } directed_row_t;

    localparam int DIRECTED_ROWS = 28;

    directed_row_t directed_rows [0:DIRECTED_ROWS-1] = '{
        // input bank: reset contents, edges of the range, zero quantity
        '{OP_RD_INPUT,    16'd0,     16'd8,     8'd0,   16'h0000, 1'b1, ST_OK,     16'h1000},
        '{OP_RD_INPUT,    16'd0,     16'd8,     8'd7,   16'hFFFF, 1'b1, ST_OK,     16'h1007},
        '{OP_RD_INPUT,    16'd1,     16'd8,     8'd0,   16'h0000, 1'b1, ST_NOREG,  16'h0000},
        '{OP_RD_INPUT,    16'hFFFF,  16'hFFFF,  8'hFF,  16'hFFFF, 1'b1, ST_NOREG,  16'h0000},
        '{OP_RD_INPUT,    16'd8,     16'd0,     8'd0,   16'h0000, 1'b1, ST_BEYOND, 16'h0000},
        '{OP_RD_INPUT,    16'd0,     16'd2,     8'd2,   16'h0000, 1'b1, ST_BEYOND, 16'h0000},
        // holding bank: one-based start, full span, top entry
        '{OP_RD_HOLDING,  16'd0,     16'd1,     8'd0,   16'h0000, 1'b1, ST_NOREG,  16'h0000},
        '{OP_WR_HOLDING,  16'd0,     16'd1,     8'd0,   16'hBEEF, 1'b1, ST_NOREG,  16'h0000},
        '{OP_RD_HOLDING,  16'd1,     16'd256,   8'hFF,  16'h0000, 1'b1, ST_OK,     16'h0000},
        '{OP_RD_HOLDING,  16'd2,     16'd256,   8'd0,   16'h0000, 1'b1, ST_NOREG,  16'h0000},
        '{OP_WR_HOLDING,  16'd1,     16'd256,   8'd0,   16'hFFFF, 1'b1, ST_OK,     16'h0000},
        '{OP_WR_HOLDING,  16'd256,   16'd1,     8'd0,   16'hA5A5, 1'b1, ST_OK,     16'h0000},
        '{OP_WR_HOLDING,  16'd10,    16'd2,     8'd2,   16'h1234, 1'b1, ST_BEYOND, 16'h0000},
        '{OP_RD_HOLDING,  16'd1,     16'd1,     8'd0,   16'h0000, 1'b0, ST_OK,     16'h0000},
        '{OP_RD_HOLDING,  16'd250,   16'd7,     8'd6,   16'h0000, 1'b0, ST_OK,     16'h0000},
        // coils: reset bytes, range edges, short last byte, write offset
        '{OP_RD_COILS,    16'd0,     16'd16,    8'd0,   16'h0000, 1'b1, ST_OK,     16'h0001},
        '{OP_RD_COILS,    16'd0,     16'd16,    8'd1,   16'h0000, 1'b1, ST_OK,     16'h0002},
        '{OP_RD_COILS,    16'd0,     16'd17,    8'd0,   16'h0000, 1'b1, ST_NOREG,  16'h0000},
        '{OP_RD_COILS,    16'd16,    16'd0,     8'd0,   16'h0000, 1'b1, ST_BEYOND, 16'h0000},
        '{OP_RD_COILS,    16'd0,     16'd9,     8'd2,   16'h0000, 1'b1, ST_BEYOND, 16'h0000},
        '{OP_RD_COILS,    16'd3,     16'd13,    8'd1,   16'h0000, 1'b0, ST_OK,     16'h0000},
        '{OP_WR_COILS,    16'd4,     16'd12,    8'd1,   16'hFFFF, 1'b0, ST_OK,     16'h0000},
        '{OP_WR_COILS,    16'd4,     16'd12,    8'd0,   16'h55AA, 1'b0, ST_OK,     16'h0000},
        '{OP_RD_COILS,    16'd0,     16'd16,    8'd1,   16'h0000, 1'b0, ST_OK,     16'h0000},
        // discrete inputs and the spare opcodes
        '{OP_RD_DISCRETE, 16'd0,     16'd16,    8'd1,   16'h0000, 1'b1, ST_OK,     16'h0002},
        '{OP_RD_DISCRETE, 16'd9,     16'd7,     8'd0,   16'h0000, 1'b0, ST_OK,     16'h0000},
        '{OP_SPARE_6,     16'd0,     16'd1,     8'd0,   16'h0000, 1'b1, ST_NOREG,  16'h0000},
        '{OP_SPARE_7,     16'hFFFF,  16'hFFFF,  8'hFF,  16'hFFFF, 1'b1, ST_NOREG,  16'h0000}
    };

    logic                   aclk;
    logic                   aresetn  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata  = '0;
    logic [S_TUSER_W-1:0]   s_tuser  = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic [M_TUSER_W-1:0]   m_tuser;

    // Bench copy of the banks
    logic [15:0]               holding_image [HOLDING_COUNT];
    logic [COIL_COUNT-1:0]     coil_image;
    logic [DISCRETE_COUNT-1:0] discrete_image;

    answer_t expected_answers [$];

    bit idle_on = 1'b1;      // stall bursts allowed on both streams
    int error_count    = 0;
    int mismatch_count = 0;
    int answers_seen   = 0;
    int elements_sent  = 0;
    int ok_count = 0, noreg_count = 0, beyond_count = 0;
    int cycle_count = 0;

    modbus_register_map dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Run the bank model for one element; writes update the bench banks
    function automatic answer_t predict_answer(input request_t req);
        answer_t     ans;
        int unsigned start_u, qty_u, idx_u, base, size, left, nbits, pos, p;
        ans.st    = ST_OK;
        ans.rdata = 16'h0000;
        start_u   = req.start_addr;
        qty_u     = req.qty;
        idx_u     = req.idx;
        case (req.op)
            OP_RD_INPUT, OP_RD_HOLDING, OP_WR_HOLDING: begin
                size = (req.op == OP_RD_INPUT) ? INPUT_COUNT : HOLDING_COUNT;
                base = (req.op == OP_RD_INPUT) ? start_u : start_u - 1;
                if ((req.op != OP_RD_INPUT && start_u == 0) || base + qty_u > size) begin
                    ans.st = ST_NOREG;
                end else if (idx_u >= qty_u) begin
                    ans.st = ST_BEYOND;
                end else if (req.op == OP_RD_INPUT) begin
                    ans.rdata = INPUT_BASE + 16'(base + idx_u);
                end else if (req.op == OP_RD_HOLDING) begin
                    ans.rdata = holding_image[base + idx_u];
                end else begin
                    holding_image[base + idx_u] = req.wdata;
                end
            end
            OP_RD_COILS, OP_WR_COILS, OP_RD_DISCRETE: begin
                size = (req.op == OP_RD_DISCRETE) ? DISCRETE_COUNT : COIL_COUNT;
                if (start_u + qty_u > size) begin
                    ans.st = ST_NOREG;
                end else if (idx_u >= ((qty_u + 7) >> 3)) begin
                    ans.st = ST_BEYOND;
                end else begin
                    // the last byte carries only the bits left in the request
                    left  = qty_u - 8 * idx_u;
                    nbits = (left > 8) ? 8 : left;
                    pos   = start_u + 8 * idx_u;
                    for (int k = 0; k < nbits; k++) begin
                        p = pos + k;
                        if (p < size) begin
                            if (req.op == OP_RD_COILS)
                                ans.rdata[k] = coil_image[p];
                            else if (req.op == OP_RD_DISCRETE)
                                ans.rdata[k] = discrete_image[p];
                            else
                                coil_image[p] = req.wdata[k];
                        end
                    end
                end
            end
            default: begin
                ans.st = ST_NOREG;
            end
        endcase
        return ans;
    endfunction

    // Index within or just past the request's element count
    function automatic logic [7:0] pick_index(input int unsigned limit);
        if (limit > 0 && $urandom_range(0, 9) != 0)
            return 8'($urandom_range(0, limit - 1));
        return 8'(limit + $urandom_range(0, 2));
    endfunction

    // Mostly well-formed requests with random content, some pure noise
    function automatic request_t make_request();
        request_t    req;
        int unsigned lim, size;
        req.wdata = 16'($urandom);
        if ($urandom_range(0, 7) == 0) begin
            req.op         = 3'($urandom_range(0, 7));
            req.start_addr = 16'($urandom);
            req.qty        = ($urandom_range(0, 1) == 0) ? 16'($urandom)
                                                         : 16'($urandom_range(0, 20));
            req.idx        = 8'($urandom);
            return req;
        end
        req.op = 3'($urandom_range(OP_RD_INPUT, OP_RD_DISCRETE));
        case (req.op)
            OP_RD_INPUT: begin
                req.start_addr = 16'($urandom_range(0, INPUT_COUNT));
                req.qty        = 16'($urandom_range(0, INPUT_COUNT - req.start_addr));
                req.idx        = pick_index(req.qty);
            end
            OP_RD_HOLDING, OP_WR_HOLDING: begin
                // keep most traffic in a small window so reads see earlier writes
                req.start_addr = ($urandom_range(0, 4) != 0) ? 16'($urandom_range(1, 24))
                                                             : 16'($urandom_range(1, HOLDING_COUNT));
                lim            = HOLDING_COUNT + 1 - req.start_addr;
                req.qty        = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, lim))
                                                             : 16'($urandom_range(1, (lim < 8) ? lim : 8));
                req.idx        = pick_index(req.qty);
            end
            default: begin
                size           = (req.op == OP_RD_DISCRETE) ? DISCRETE_COUNT : COIL_COUNT;
                req.start_addr = 16'($urandom_range(0, size));
                req.qty        = 16'($urandom_range(0, size - req.start_addr));
                req.idx        = pick_index((req.qty + 7) >> 3);
            end
        endcase
        return req;
    endfunction

    // Drive one element and hold it until the handshake completes.
    // Handshakes are sampled at the falling edge, where everything is settled.
    task automatic send_element(input request_t req);
        bit fire;
        s_tvalid <= 1'b1;
        s_tdata  <= {req.wdata, req.idx, req.qty, req.start_addr};
        s_tuser  <= req.op;
        do begin
            @(negedge aclk);
            fire = (s_tready === 1'b1);
            @(posedge aclk);
        end while (!fire);
        elements_sent++;
    endtask

    task automatic queue_answer(input answer_t ans);
        expected_answers.push_back(ans);
        case (ans.st)
            ST_OK:    ok_count++;
            ST_NOREG: noreg_count++;
            default:  beyond_count++;
        endcase
    endtask

    // Drop valid for a random burst, only while idling is enabled
    task automatic maybe_gap();
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge aclk);
        end
    endtask

    // Hold the sender until every outstanding answer has come back
    task automatic drain_answers();
        s_tvalid <= 1'b0;
        while (expected_answers.size() != 0) @(posedge aclk);
    endtask

    // Result side: ready with random stall bursts while idling is enabled
    initial begin
        wait (aresetn === 1'b1);
        forever begin
            @(posedge aclk);
            if (idle_on && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge aclk);
            end
            m_tready <= 1'b1;
        end
    end

    // Compare each answer beat against the oldest prediction
    always @(negedge aclk) begin
        answer_t want;
        if (aresetn === 1'b1 && m_tvalid === 1'b1 && m_tready === 1'b1) begin
            answers_seen++;
            if (expected_answers.size() == 0) begin
                error_count++;
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("[%0t] unexpected answer: status %0d data %h",
                             $realtime, m_tuser, m_tdata);
            end else begin
                want = expected_answers.pop_front();
                if (m_tuser !== want.st || m_tdata !== want.rdata) begin
                    error_count++;
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS) begin
                        if (m_tuser !== want.st)
                            $display("[%0t] answer %0d status: expected %0d got %0d",
                                     $realtime, answers_seen, want.st, m_tuser);
                        if (m_tdata !== want.rdata)
                            $display("[%0t] answer %0d read_data: expected %h got %h",
                                     $realtime, answers_seen, want.rdata, m_tdata);
                    end
                end
            end
        end
    end

    // Watchdog: covers the post-reset sweep and the worst idling
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d answers outstanding",
                     cycle_count, expected_answers.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        request_t req;
        answer_t  ans;
        int       tail;

        for (int i = 0; i < HOLDING_COUNT; i++) holding_image[i] = 16'h0000;
        coil_image     = COIL_COUNT'(BIT_RESET_WORD);
        discrete_image = DISCRETE_COUNT'(BIT_RESET_WORD);

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed table; the model still runs on typed rows to track writes
        for (int r = 0; r < DIRECTED_ROWS; r++) begin
            req.op         = directed_rows[r].op;
            req.start_addr = directed_rows[r].start_addr;
            req.qty        = directed_rows[r].qty;
            req.idx        = directed_rows[r].idx;
            req.wdata      = directed_rows[r].wdata;
            send_element(req);
            ans = predict_answer(req);
            if (directed_rows[r].typed) begin
                ans.st    = directed_rows[r].st;
                ans.rdata = directed_rows[r].rdata;
            end
            queue_answer(ans);
            maybe_gap();
        end
        drain_answers();

        // Random part: alternate idling and clean stretches, none at the end
        for (int n = 0; n < RANDOM_ELEMENTS; n++) begin
            idle_on = (n < RANDOM_ELEMENTS - 200) && ((n / 100) % 3 != 2);
            if (n == RANDOM_ELEMENTS / 2)
                drain_answers();
            req = make_request();
            send_element(req);
            queue_answer(predict_answer(req));
            maybe_gap();
        end
        s_tvalid <= 1'b0;

        while (expected_answers.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        tail = expected_answers.size();
        error_count += tail;

        $display("Sent %0d request elements (%0d directed) with stalls on both streams.",
                 elements_sent, DIRECTED_ROWS);
        $display("Answers: %0d ok, %0d no-register, %0d beyond-request; %0d mismatches.",
                 ok_count, noreg_count, beyond_count, mismatch_count);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
